FILE: sv/tmcw_pkg.sv
// Shared types and constants of the text-mode console writer.
package tmcw_pkg;

    localparam int ROW_W    = 6;
    localparam int COL_W    = 7;
    localparam int SCROLL_W = 3;
    localparam int CURSOR_W = 11;
    localparam int ADDR_W   = 11;
    localparam int CHAR_W   = 8;
    localparam int CELL_W   = 16;
    localparam int TAB_STEP = 4;

    localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_HT    = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_VT    = 8'd11;
    localparam logic [CHAR_W-1:0] CODE_FF    = 8'd12;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] PRINT_LO   = 8'd32;
    localparam logic [CHAR_W-1:0] PRINT_HI   = 8'd126;
    localparam logic [CHAR_W-1:0] BLANK_CODE = 8'd32;
    localparam logic [CHAR_W-1:0] DEFAULT_ATTR_RESET = 8'd7;

    localparam logic OP_SHOW = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic                accepted;
        logic                write_en;
        logic                blank;
        logic                clear;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [SCROLL_W-1:0] scroll_cnt;
    } step_t;

endpackage

FILE: sv/tmcw_cell_ram.sv
// Cell memory: one write port, one read port with registered read data.
module tmcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [tmcw_pkg::CELL_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [tmcw_pkg::CELL_W-1:0] rd_data
);
    import tmcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/tmcw_step.sv
// Cursor step: decodes a shown code into the new cursor, cell write and scroll count.
module tmcw_step #(
    parameter int SCREEN_ROWS    = 25,
    parameter int SCREEN_COLUMNS = 80
) (
    input  logic [tmcw_pkg::ROW_W-1:0]  row,
    input  logic [tmcw_pkg::COL_W-1:0]  col,
    input  logic [tmcw_pkg::CHAR_W-1:0] char_code,
    output tmcw_pkg::step_t             step
);
    import tmcw_pkg::*;

    localparam logic [ROW_W:0] LAST_ROW = (ROW_W+1)'(SCREEN_ROWS - 1);
    localparam logic [COL_W:0] COLS     = (COL_W+1)'(SCREEN_COLUMNS);
    localparam logic [COL_W:0] LAST_COL = (COL_W+1)'(SCREEN_COLUMNS - 1);

    logic [ROW_W:0] row_wide;
    logic [COL_W:0] col_wide;
    logic [COL_W:0] tab_col;
    logic [ROW_W:0] tab_row;

    assign tab_col = (COL_W+1)'(col & ~COL_W'(TAB_STEP - 1)) + (COL_W+1)'(TAB_STEP);
    assign tab_row = (ROW_W+1)'(row & ~ROW_W'(TAB_STEP - 1)) + (ROW_W+1)'(TAB_STEP);

    always_comb begin
        step     = '0;
        row_wide = {1'b0, row};
        col_wide = {1'b0, col};
        unique case (char_code) inside
            [PRINT_LO:PRINT_HI]: begin
                step.accepted = 1'b1;
                step.write_en = 1'b1;
                col_wide = {1'b0, col} + (COL_W+1)'(1);
                if (col_wide == COLS) begin
                    col_wide = '0;
                    row_wide = {1'b0, row} + (ROW_W+1)'(1);
                end
            end
            CODE_BS: begin
                step.accepted = 1'b1;
                if (col != '0) begin
                    col_wide      = {1'b0, col} - (COL_W+1)'(1);
                    step.write_en = 1'b1;
                    step.blank    = 1'b1;
                end else begin
                    col_wide = LAST_COL;
                    if (row != '0) begin
                        row_wide      = {1'b0, row} - (ROW_W+1)'(1);
                        step.write_en = 1'b1;
                        step.blank    = 1'b1;
                    end
                end
            end
            CODE_HT: begin
                step.accepted = 1'b1;
                if (tab_col >= COLS) begin
                    col_wide = tab_col - COLS;
                    row_wide = {1'b0, row} + (ROW_W+1)'(1);
                end else begin
                    col_wide = tab_col;
                end
            end
            CODE_LF: begin
                step.accepted = 1'b1;
                row_wide = {1'b0, row} + (ROW_W+1)'(1);
            end
            CODE_VT: begin
                step.accepted = 1'b1;
                row_wide = tab_row;
            end
            CODE_FF: begin
                step.accepted = 1'b1;
                step.clear    = 1'b1;
                row_wide = '0;
                col_wide = '0;
            end
            CODE_CR: begin
                step.accepted = 1'b1;
                col_wide = '0;
            end
            default: begin
                step.accepted = 1'b0;
            end
        endcase
        if (row_wide > LAST_ROW) begin
            step.scroll_cnt = SCROLL_W'(row_wide - LAST_ROW);
            row_wide        = LAST_ROW;
        end
        step.row = row_wide[ROW_W-1:0];
        step.col = col_wide[COL_W-1:0];
    end

endmodule

FILE: sv/text_mode_console_writer.sv
// Top level of the text-mode console writer: sequencer around the cell memory.
//
//   port group      dir  contents
//   s_t*            in   words to show or cells to read
//   m_t*            out  one result word per input word
//   cfg_*           in   default attribute register
//
// A word passes from accept through decode to a read or cursor update and then to the
// result register; an ignored code or an out-of-range read skips the middle step, and
// the next word is accepted once the result is registered. Each scroll adds one sweep
// over all cells (up to four for a vertical tab), and form feed adds one.
// After reset a clearing pass over all cells runs before the first accept.
// A result waits in the output register while the next word is accepted.
module text_mode_console_writer #(
    parameter int SCREEN_ROWS    = 25,
    parameter int SCREEN_COLUMNS = 80
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code, char_attr, read_addr
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cursor_pos, cell_char, cell_attr, was_accepted
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata
);
    import tmcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam logic [AW-1:0] LAST_CELL   = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] SCROLL_SPAN = AW'(CELL_COUNT - SCREEN_COLUMNS);
    localparam logic [AW-1:0] ROW_OFFSET  = AW'(SCREEN_COLUMNS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_SCROLL,
        ST_LIN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic                 opcode_reg;
    logic [CHAR_W-1:0]    code_reg;
    logic [CHAR_W-1:0]    attr_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic [AW-1:0]        lin_reg;
    logic [AW-1:0]        sweep_reg;
    logic [SCROLL_W-1:0]  scroll_reg;
    logic                 boot_reg;
    logic                 pend_valid_reg;
    logic [AW-1:0]        pend_addr_reg;
    logic                 pend_blank_reg;
    logic [CELL_W-1:0]    cell_reg;
    logic                 acc_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic [CHAR_W-1:0]    default_attr_reg;

    step_t                step;
    logic                 addr_valid;
    logic [CELL_W-1:0]    fill_cell;
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [CELL_W-1:0]    ram_wr_data;
    logic [AW-1:0]        ram_rd_addr;
    logic [CELL_W-1:0]    ram_rd_data;

    tmcw_step #(
        .SCREEN_ROWS    (SCREEN_ROWS),
        .SCREEN_COLUMNS (SCREEN_COLUMNS)
    ) u_step (
        .row       (row_reg),
        .col       (col_reg),
        .char_code (code_reg),
        .step      (step)
    );

    tmcw_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign addr_valid = int'(addr_reg) < CELL_COUNT;
    assign fill_cell  = boot_reg ? '0 : {default_attr_reg, BLANK_CODE};

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = lin_reg;
        ram_wr_data = {attr_reg, step.blank ? BLANK_CODE : code_reg};
        if (pend_valid_reg) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pend_addr_reg;
            ram_wr_data = pend_blank_reg ? fill_cell : ram_rd_data;
        end else if (state_reg == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_reg;
            ram_wr_data = fill_cell;
        end else if (state_reg == ST_DECODE && opcode_reg == OP_SHOW && step.accepted
                     && step.write_en) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = step.blank ? lin_reg - AW'(1) : lin_reg;
        end
    end

    assign ram_rd_addr = (state_reg == ST_SCROLL) ? sweep_reg + ROW_OFFSET : AW'(addr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            sweep_reg        <= '0;
            scroll_reg       <= '0;
            boot_reg         <= 1'b1;
            pend_valid_reg   <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            default_attr_reg <= DEFAULT_ATTR_RESET;
            row_reg          <= '0;
            col_reg          <= '0;
            lin_reg          <= '0;
        end else begin
            if (cfg_wen) begin
                default_attr_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            pend_valid_reg <= (state_reg == ST_SCROLL);
            unique case (state_reg)
                ST_CLEAR: begin
                    if (sweep_reg == LAST_CELL) begin
                        sweep_reg <= '0;
                        boot_reg  <= 1'b0;
                        state_reg <= boot_reg ? ST_IDLE : ST_LIN;
                    end else begin
                        sweep_reg <= sweep_reg + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        opcode_reg <= s_tuser;
                        code_reg   <= s_tdata[7:0];
                        attr_reg   <= s_tdata[15:8];
                        addr_reg   <= s_tdata[26:16];
                        state_reg  <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    cell_reg <= '0;
                    if (opcode_reg == OP_READ) begin
                        acc_reg   <= 1'b1;
                        state_reg <= addr_valid ? ST_READ : ST_DONE;
                    end else if (!step.accepted) begin
                        acc_reg   <= 1'b0;
                        state_reg <= ST_DONE;
                    end else begin
                        acc_reg    <= 1'b1;
                        row_reg    <= step.row;
                        col_reg    <= step.col;
                        scroll_reg <= step.scroll_cnt;
                        if (step.clear) begin
                            state_reg <= ST_CLEAR;
                        end else if (step.scroll_cnt != '0) begin
                            state_reg <= ST_SCROLL;
                        end else begin
                            state_reg <= ST_LIN;
                        end
                    end
                end
                ST_READ: begin
                    cell_reg  <= ram_rd_data;
                    state_reg <= ST_DONE;
                end
                ST_SCROLL: begin
                    pend_addr_reg  <= sweep_reg;
                    pend_blank_reg <= sweep_reg >= SCROLL_SPAN;
                    if (sweep_reg == LAST_CELL) begin
                        sweep_reg  <= '0;
                        scroll_reg <= scroll_reg - SCROLL_W'(1);
                        if (scroll_reg == SCROLL_W'(1)) begin
                            state_reg <= ST_LIN;
                        end
                    end else begin
                        sweep_reg <= sweep_reg + AW'(1);
                    end
                end
                ST_LIN: begin
                    lin_reg   <= AW'(int'(row_reg) * SCREEN_COLUMNS + int'(col_reg));
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {4'b0000, acc_reg, cell_reg[15:8], cell_reg[7:0],
                                         CURSOR_W'(lin_reg)};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the text-mode console writer: scoreboard with cell-buffer predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcw_pkg::*;

    localparam int ROWS        = 25;
    localparam int COLS        = 80;
    localparam int CELLS       = ROWS * COLS;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_pos;
        logic [CHAR_W-1:0]   cell_char;
        logic [CHAR_W-1:0]   cell_attr;
        logic                was_accepted;
    } console_result_t;

    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELLS];
        int                cursor;
        logic [CHAR_W-1:0] dflt_attr;
        console_result_t   result_q[$];
        int                errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cursor    = 0;
            dflt_attr = DEFAULT_ATTR_RESET;
            errors    = 0;
        endfunction

        function bit code_known(logic [CHAR_W-1:0] c);
            return (c >= PRINT_LO && c <= PRINT_HI) || (c >= CODE_BS && c <= CODE_CR);
        endfunction

        function void place_cursor(int row, int col);
            while (col >= COLS) begin
                col -= COLS;
                row++;
            end
            while (row >= ROWS) begin
                row--;
                for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
                for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = {dflt_attr, BLANK_CODE};
            end
            while (col < 0) begin
                col += COLS;
                row--;
            end
            if (row < 0) row = 0;
            cursor = row * COLS + col;
        endfunction

        function void note_word(logic op, logic [CHAR_W-1:0] code, logic [CHAR_W-1:0] attr,
                                logic [ADDR_W-1:0] addr);
            console_result_t r;
            int row, col, lin;
            r = '0;
            if (op == OP_READ) begin
                if (addr < CELLS) begin
                    r.cell_char = cells[addr][7:0];
                    r.cell_attr = cells[addr][15:8];
                end
                r.was_accepted = 1'b1;
            end else if (code_known(code)) begin
                row = cursor / COLS;
                col = cursor % COLS;
                r.was_accepted = 1'b1;
                case (code)
                    CODE_LF: row++;
                    CODE_CR: col = 0;
                    CODE_BS: begin
                        col--;
                        lin = row * COLS + col;
                        if (lin >= 0 && lin < CELLS) cells[lin] = {attr, BLANK_CODE};
                    end
                    CODE_HT: col = (col / TAB_STEP) * TAB_STEP + TAB_STEP;
                    CODE_VT: row = (row / TAB_STEP) * TAB_STEP + TAB_STEP;
                    CODE_FF: begin
                        foreach (cells[i]) cells[i] = {dflt_attr, BLANK_CODE};
                        row = 0;
                        col = 0;
                    end
                    default: begin
                        lin = row * COLS + col;
                        if (lin >= 0 && lin < CELLS) cells[lin] = {attr, code};
                        col++;
                    end
                endcase
                place_cursor(row, col);
            end
            r.cursor_pos = cursor[CURSOR_W-1:0];
            result_q.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_word(logic [31:0] data);
            console_result_t want;
            if (result_q.size() == 0) begin
                report_mismatch("word with nothing pending", data, 0);
                return;
            end
            want = result_q.pop_front();
            if (data[10:0] !== want.cursor_pos)
                report_mismatch("cursor_pos", int'(data[10:0]), int'(want.cursor_pos));
            if (data[18:11] !== want.cell_char)
                report_mismatch("cell_char", int'(data[18:11]), int'(want.cell_char));
            if (data[26:19] !== want.cell_attr)
                report_mismatch("cell_attr", int'(data[26:19]), int'(want.cell_attr));
            if (data[27] !== want.was_accepted)
                report_mismatch("was_accepted", int'(data[27]), int'(want.was_accepted));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_wen;
    logic [7:0]  cfg_wdata;

    console_scoreboard sb = new();
    bit     tx_idle_on = 1'b1;
    bit     rx_idle_on = 1'b1;
    longint cycle_count = 0;

    text_mode_console_writer #(
        .SCREEN_ROWS    (ROWS),
        .SCREEN_COLUMNS (COLS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tdata);
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic op, input logic [7:0] code, input logic [7:0] attr,
                             input logic [10:0] addr);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, addr, attr, code};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, code, attr, addr);
    endtask

    task automatic random_word();
        int          pick;
        logic        op;
        logic [7:0]  code;
        logic [10:0] addr;
        pick = $urandom_range(0, 99);
        op   = OP_SHOW;
        code = 8'($urandom_range(PRINT_LO, PRINT_HI));
        addr = 11'($urandom_range(0, 2047));
        if (pick < 15) begin
            op   = OP_READ;
            code = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1)
                addr = 11'((sb.cursor + CELLS - $urandom_range(1, 8)) % CELLS);
        end else if (pick >= 70 && pick < 76) begin
            code = CODE_LF;
        end else if (pick >= 76 && pick < 79) begin
            code = CODE_CR;
        end else if (pick >= 79 && pick < 83) begin
            code = CODE_BS;
        end else if (pick >= 83 && pick < 87) begin
            code = CODE_HT;
        end else if (pick >= 87 && pick < 89) begin
            code = CODE_VT;
        end else if (pick == 89) begin
            code = CODE_FF;
        end else if (pick >= 90) begin
            do code = 8'($urandom_range(0, 255)); while (sb.code_known(code));
        end
        send_word(op, code, 8'($urandom_range(0, 255)), addr);
    endtask

    task automatic wait_idle();
        while (sb.result_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_default_attr(input logic [7:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        sb.dflt_attr = value;
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(OP_READ, 8'd0, 8'd0, 11'd0);
        send_word(OP_READ, 8'hFF, 8'hFF, 11'd2047);
        send_word(OP_SHOW, 8'd65, 8'h00, 11'd0);
        send_word(OP_SHOW, PRINT_HI, 8'hFF, 11'd2047);
        send_word(OP_SHOW, PRINT_LO, 8'h5A, 11'd0);
        send_word(OP_READ, 8'd0, 8'd0, 11'd1);
        send_word(OP_SHOW, 8'd31, 8'h11, 11'd0);
        send_word(OP_SHOW, 8'd127, 8'h22, 11'd0);
        send_word(OP_SHOW, 8'd128, 8'h33, 11'd0);
        send_word(OP_SHOW, 8'd255, 8'h44, 11'd0);
        send_word(OP_SHOW, CODE_BS, 8'hA5, 11'd0);
        send_word(OP_SHOW, CODE_CR, 8'h00, 11'd0);
        send_word(OP_SHOW, CODE_BS, 8'h3C, 11'd0);
        send_word(OP_SHOW, CODE_HT, 8'h00, 11'd0);
        send_word(OP_SHOW, CODE_HT, 8'h00, 11'd0);
        send_word(OP_SHOW, CODE_LF, 8'h00, 11'd0);
        send_word(OP_SHOW, CODE_VT, 8'h00, 11'd0);
        send_word(OP_SHOW, CODE_FF, 8'h00, 11'd0);
        send_word(OP_READ, 8'd0, 8'd0, 11'd1999);
        send_word(OP_READ, 8'd0, 8'd0, 11'd2000);
        repeat (7) send_word(OP_SHOW, CODE_VT, 8'h00, 11'd0);
        send_word(OP_READ, 8'd0, 8'd0, 11'd1999);

        for (int phase = 0; phase < 4; phase++) begin
            s_tvalid <= 1'b0;
            wait_idle();
            case (phase)
                0:       write_default_attr(8'h00);
                1:       write_default_attr(8'hFF);
                default: write_default_attr(8'($urandom_range(0, 255)));
            endcase
            if (phase == 3) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            send_word(OP_SHOW, CODE_FF, 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)));
            repeat (200) random_word();
        end

        s_tvalid <= 1'b0;
        wait_idle();
        if (sb.errors == 0 && sb.result_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: filelist.f
sv/tmcw_pkg.sv
sv/tmcw_cell_ram.sv
sv/tmcw_step.sv
sv/text_mode_console_writer.sv
tb/sv/tb_top.sv
